@@ sv/nat_pkg.sv @@
package nat_pkg;

	localparam int ADDR_W          = 48;
	localparam int FOUND_W         = 32;
	localparam int COUNT_OUT_W     = 5;
	localparam int OUT_TDATA_W     = ((FOUND_W + ADDR_W + COUNT_OUT_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W     = 4;
	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_PAYLOAD_BITS = 32;

	typedef enum logic [1:0] {
		CMD_STORE  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_FORGET = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [1:0] CH_NONE    = 2'd0;
	localparam logic [1:0] CH_ADDED   = 2'd1;
	localparam logic [1:0] CH_UPDATED = 2'd2;
	localparam logic [1:0] CH_REMOVED = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic rd_en;
		logic rd_tail;
		logic idx_inc;
		logic chk;
		logic act;
		logic fwr;
		logic emit;
		logic emit_list;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic match;
		logic idx_last;
		logic count_zero;
		logic hit;
		logic fwd_move;
		logic out_free;
	} dp_stat_t;

endpackage

@@ sv/nat_datapath.sv @@
module nat_datapath #(
	parameter int MAX_ENTRIES  = nat_pkg::DEF_MAX_ENTRIES,
	parameter int PAYLOAD_BITS = nat_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nat_pkg::ctrl_cmd_t              cmd_i,
	output nat_pkg::dp_stat_t               stat_o,
	input  logic [1:0]                      in_cmd,
	input  logic [nat_pkg::ADDR_W-1:0]      in_addr,
	input  logic [PAYLOAD_BITS-1:0]         in_pay,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [nat_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [nat_pkg::OUT_TUSER_W-1:0] m_tuser,
	output logic                            m_tlast
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [nat_pkg::ADDR_W-1:0] addr_mem [MAX_ENTRIES];
	logic [PAYLOAD_BITS-1:0]    pay_mem  [MAX_ENTRIES];

	logic [CW-1:0]              count_q;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              slot_q;
	logic                       hit_q;
	nat_pkg::cmd_t              cmd_q;
	logic [nat_pkg::ADDR_W-1:0] key_q;
	logic [PAYLOAD_BITS-1:0]    pay_q;
	logic [nat_pkg::ADDR_W-1:0] rd_addr_q;
	logic [PAYLOAD_BITS-1:0]    rd_pay_q;

	logic [1:0]                 res_status_q;
	logic [1:0]                 res_change_q;
	logic [nat_pkg::FOUND_W-1:0] res_found_q;

	logic                       m_tvalid_q;
	logic [1:0]                 out_status_q;
	logic [1:0]                 out_change_q;
	logic [nat_pkg::FOUND_W-1:0] out_found_q;
	logic [nat_pkg::ADDR_W-1:0] out_listed_q;
	logic [nat_pkg::COUNT_OUT_W-1:0] out_count_q;
	logic                       out_last_q;

	logic                       full;
	logic                       idx_last;
	logic                       fwd_move;
	logic                       out_free;
	logic                       load;
	logic                       we_addr;
	logic                       we_pay;
	logic [IW-1:0]              wr_idx;
	logic [nat_pkg::ADDR_W-1:0] wr_addr;
	logic [PAYLOAD_BITS-1:0]    wr_pay;
	logic [IW-1:0]              rd_idx;
	logic [63:0]                rd_pay_wide;
	logic [7:0]                 count_wide;

	assign full        = (count_q == CW'(MAX_ENTRIES));
	assign idx_last    = ((CW'(idx_q) + CW'(1)) == count_q);
	assign fwd_move    = hit_q && ((CW'(slot_q) + CW'(1)) != count_q);
	assign out_free    = !m_tvalid_q || m_tready;
	assign load        = cmd_i.emit || cmd_i.emit_list;
	assign rd_idx      = cmd_i.rd_tail ? IW'(count_q - CW'(1)) : idx_q;
	assign rd_pay_wide = 64'(rd_pay_q);
	assign count_wide  = 8'(count_q);

	assign stat_o.cmd        = cmd_q;
	assign stat_o.match      = (rd_addr_q == key_q);
	assign stat_o.idx_last   = idx_last;
	assign stat_o.count_zero = (count_q == '0);
	assign stat_o.hit        = hit_q;
	assign stat_o.fwd_move   = fwd_move;
	assign stat_o.out_free   = out_free;

	// table writes: store in the act step, tail move on forget
	always_comb begin
		we_addr = 1'b0;
		we_pay  = 1'b0;
		wr_idx  = slot_q;
		wr_addr = key_q;
		wr_pay  = pay_q;
		if (cmd_i.fwr) begin
			we_addr = 1'b1;
			we_pay  = 1'b1;
			wr_addr = rd_addr_q;
			wr_pay  = rd_pay_q;
		end else if (cmd_i.act && cmd_q == nat_pkg::CMD_STORE) begin
			if (hit_q) begin
				we_pay = 1'b1;
			end else if (!full) begin
				we_addr = 1'b1;
				we_pay  = 1'b1;
				wr_idx  = IW'(count_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we_addr) begin
			addr_mem[wr_idx] <= wr_addr;
		end
		if (we_pay) begin
			pay_mem[wr_idx] <= wr_pay;
		end
		if (cmd_i.rd_en) begin
			rd_addr_q <= addr_mem[rd_idx];
			rd_pay_q  <= pay_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			hit_q      <= 1'b0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd_i.cap) begin
				hit_q <= 1'b0;
				idx_q <= '0;
			end else if (cmd_i.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd_i.chk && stat_o.match) begin
				hit_q <= 1'b1;
			end
			if (cmd_i.fwr) begin
				count_q <= count_q - CW'(1);
			end else if (cmd_i.act) begin
				case (cmd_q)
					nat_pkg::CMD_STORE: begin
						if (!hit_q && !full) begin
							count_q <= count_q + CW'(1);
						end
					end
					nat_pkg::CMD_FORGET: begin
						if (hit_q && !fwd_move) begin
							count_q <= count_q - CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.cap) begin
			cmd_q        <= nat_pkg::cmd_t'(in_cmd);
			key_q        <= in_addr;
			pay_q        <= in_pay;
			res_status_q <= nat_pkg::ST_OK;
			res_change_q <= nat_pkg::CH_NONE;
			res_found_q  <= '0;
		end
		if (cmd_i.chk && stat_o.match) begin
			slot_q <= idx_q;
		end
		if (cmd_i.fwr) begin
			res_change_q <= nat_pkg::CH_REMOVED;
		end else if (cmd_i.act) begin
			case (cmd_q)
				nat_pkg::CMD_STORE: begin
					if (hit_q) begin
						res_change_q <= nat_pkg::CH_UPDATED;
					end else if (full) begin
						res_status_q <= nat_pkg::ST_FULL;
					end else begin
						res_change_q <= nat_pkg::CH_ADDED;
					end
				end
				nat_pkg::CMD_LOOKUP: begin
					if (hit_q) begin
						res_found_q <= rd_pay_wide[nat_pkg::FOUND_W-1:0];
					end else begin
						res_status_q <= nat_pkg::ST_NOT_FOUND;
					end
				end
				nat_pkg::CMD_FORGET: begin
					if (!hit_q) begin
						res_status_q <= nat_pkg::ST_NOT_FOUND;
					end else if (!fwd_move) begin
						res_change_q <= nat_pkg::CH_REMOVED;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd_i.emit_list) begin
			out_status_q <= nat_pkg::ST_OK;
			out_change_q <= nat_pkg::CH_NONE;
			out_found_q  <= '0;
			out_listed_q <= rd_addr_q;
			out_count_q  <= count_wide[nat_pkg::COUNT_OUT_W-1:0];
			out_last_q   <= idx_last;
		end else if (cmd_i.emit) begin
			out_status_q <= res_status_q;
			out_change_q <= res_change_q;
			out_found_q  <= res_found_q;
			out_listed_q <= '0;
			out_count_q  <= count_wide[nat_pkg::COUNT_OUT_W-1:0];
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(nat_pkg::OUT_TDATA_W - nat_pkg::FOUND_W - nat_pkg::ADDR_W
			- nat_pkg::COUNT_OUT_W){1'b0}}, out_count_q, out_listed_q, out_found_q};
	assign m_tuser  = {out_change_q, out_status_q};
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result loaded over an untaken transfer");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
		|| count_q == $past(count_q) - CW'(1))
		else $error("entry count moved by more than one");
`endif

endmodule

@@ sv/nat_ctrl.sv @@
module nat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [1:0]         in_cmd,
	input  nat_pkg::dp_stat_t  stat_i,
	output nat_pkg::ctrl_cmd_t cmd_o
);

	typedef enum logic [3:0] {
		IDLE,
		SRD,
		SCMP,
		ACT,
		FRD,
		FWR,
		EMIT,
		LRD,
		LOUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd_o           = '0;
		cmd_o.cap       = accept;
		case (state_q)
			SRD:  cmd_o.rd_en = 1'b1;
			SCMP: begin
				cmd_o.chk     = 1'b1;
				cmd_o.idx_inc = !stat_i.match && !stat_i.idx_last;
			end
			ACT:  cmd_o.act = 1'b1;
			FRD: begin
				cmd_o.rd_en   = 1'b1;
				cmd_o.rd_tail = 1'b1;
			end
			FWR:  cmd_o.fwr = 1'b1;
			EMIT: cmd_o.emit = stat_i.out_free;
			LRD:  cmd_o.rd_en = 1'b1;
			LOUT: begin
				cmd_o.emit_list = stat_i.out_free;
				cmd_o.idx_inc   = stat_i.out_free && !stat_i.idx_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						if (nat_pkg::cmd_t'(in_cmd) == nat_pkg::CMD_LIST) begin
							state_q <= stat_i.count_zero ? EMIT : LRD;
						end else begin
							state_q <= stat_i.count_zero ? ACT : SRD;
						end
					end
				end
				SRD:  state_q <= SCMP;
				SCMP: begin
					if (stat_i.match || stat_i.idx_last) begin
						state_q <= ACT;
					end else begin
						state_q <= SRD;
					end
				end
				ACT: begin
					// hole below the tail: pull the tail entry into it
					if (stat_i.cmd == nat_pkg::CMD_FORGET && stat_i.hit && stat_i.fwd_move) begin
						state_q <= FRD;
					end else begin
						state_q <= EMIT;
					end
				end
				FRD:  state_q <= FWR;
				FWR:  state_q <= EMIT;
				EMIT: begin
					if (stat_i.out_free) begin
						state_q <= IDLE;
					end
				end
				LRD:  state_q <= LOUT;
				LOUT: begin
					if (stat_i.out_free) begin
						state_q <= stat_i.idx_last ? IDLE : LRD;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second transfer taken while an item is in work");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.emit |=> s_tready)
		else $error("controller not idle after the final result");
`endif

endmodule

@@ sv/node_address_table.sv @@
// an input transfer runs a read step and a compare step for each slot scanned, then an act step
// and an emit step (scan stops at the first match); forget with a tail move adds a tail read and a table write
// list: a read step and an output step per entry, set by the single registered read port of the table
// one item in work at a time; s_tready is back in the cycle after the last result is registered
// reset clears the entry count, controller and output valid; table memory is not cleared
module node_address_table #(
	parameter int MAX_ENTRIES  = nat_pkg::DEF_MAX_ENTRIES,
	parameter int PAYLOAD_BITS = nat_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	// node_address, node_payload
	input  logic [((nat_pkg::ADDR_W+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
	// cmd
	input  logic [1:0]                                      s_tuser,
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	// found_payload, listed_address, entry_count
	output logic [nat_pkg::OUT_TDATA_W-1:0]                 m_tdata,
	// status, change_kind
	output logic [nat_pkg::OUT_TUSER_W-1:0]                 m_tuser,
	output logic                                            m_tlast
);

	nat_pkg::ctrl_cmd_t ctrl_cmd;
	nat_pkg::dp_stat_t  dp_stat;

	nat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_cmd   (s_tuser),
		.stat_i   (dp_stat),
		.cmd_o    (ctrl_cmd)
	);

	nat_datapath #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_i    (ctrl_cmd),
		.stat_o   (dp_stat),
		.in_cmd   (s_tuser),
		.in_addr  (s_tdata[nat_pkg::ADDR_W-1:0]),
		.in_pay   (s_tdata[nat_pkg::ADDR_W+PAYLOAD_BITS-1:nat_pkg::ADDR_W]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/node_address_table_tb.sv @@
module node_address_table_tb;

	localparam int S_TDATA_W = ((nat_pkg::ADDR_W + nat_pkg::DEF_PAYLOAD_BITS + 7) / 8) * 8;
	localparam int TABLE_DEPTH = nat_pkg::DEF_MAX_ENTRIES;
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_START = 1200;
	localparam int HOLD_LEN = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		nat_pkg::cmd_t cmd;
		logic [47:0]   addr;
		logic [31:0]   payload;
		bit            wait_idle;
	} table_cmd_t;

	typedef struct {
		logic [1:0]  status;
		logic [1:0]  change;
		logic [31:0] payload;
		logic [47:0] addr;
		logic [4:0]  count;
		logic        last;
	} table_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	// node_address, node_payload
	logic [S_TDATA_W-1:0]    s_tdata = '0;
	// cmd
	logic [1:0]              s_tuser = nat_pkg::CMD_STORE;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	// found_payload, listed_address, entry_count
	logic [nat_pkg::OUT_TDATA_W-1:0] m_tdata;
	// status, change_kind
	logic [nat_pkg::OUT_TUSER_W-1:0] m_tuser;
	logic                    m_tlast;

	node_address_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	table_cmd_t    pending_cmds[$];
	table_cmd_t    offered_cmd;
	table_result_t expected_results[$];
	table_result_t got;
	table_result_t want;

	logic [47:0] shadow_addr[TABLE_DEPTH];
	logic [31:0] shadow_payload[TABLE_DEPTH];
	int unsigned shadow_count = 0;

	int unsigned results_due = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned rx_cycle = 0;
	int unsigned rx_mode = 0;
	logic [47:0] addr_pool[POOL_SIZE];

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic table_result_t make_result(logic [1:0] status, logic [1:0] change,
			logic [31:0] payload, logic [47:0] addr, logic last);
		table_result_t r;
		r.status  = status;
		r.change  = change;
		r.payload = payload;
		r.addr    = addr;
		r.count   = shadow_count[4:0];
		r.last    = last;
		return r;
	endfunction

	function automatic int find_entry(logic [47:0] addr);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_addr[i] == addr)
				return i;
		return -1;
	endfunction

	// updates the shadow table and queues the results one command causes
	task automatic predict_table_results(table_cmd_t c);
		int slot;
		int tail;
		slot = find_entry(c.addr);
		case (c.cmd)
			nat_pkg::CMD_STORE: begin
				if (slot >= 0) begin
					shadow_payload[slot] = c.payload;
					expected_results.push_back(make_result(nat_pkg::ST_OK,
						nat_pkg::CH_UPDATED, '0, '0, 1'b1));
				end else if (shadow_count >= TABLE_DEPTH) begin
					expected_results.push_back(make_result(nat_pkg::ST_FULL,
						nat_pkg::CH_NONE, '0, '0, 1'b1));
				end else begin
					shadow_addr[shadow_count] = c.addr;
					shadow_payload[shadow_count] = c.payload;
					shadow_count++;
					expected_results.push_back(make_result(nat_pkg::ST_OK,
						nat_pkg::CH_ADDED, '0, '0, 1'b1));
				end
				results_due++;
			end
			nat_pkg::CMD_LOOKUP: begin
				if (slot >= 0)
					expected_results.push_back(make_result(nat_pkg::ST_OK, nat_pkg::CH_NONE,
						shadow_payload[slot], '0, 1'b1));
				else
					expected_results.push_back(make_result(nat_pkg::ST_NOT_FOUND,
						nat_pkg::CH_NONE, '0, '0, 1'b1));
				results_due++;
			end
			nat_pkg::CMD_FORGET: begin
				if (slot >= 0) begin
					// the tail entry fills the hole
					tail = shadow_count - 1;
					shadow_addr[slot] = shadow_addr[tail];
					shadow_payload[slot] = shadow_payload[tail];
					shadow_count = tail;
					expected_results.push_back(make_result(nat_pkg::ST_OK,
						nat_pkg::CH_REMOVED, '0, '0, 1'b1));
				end else begin
					expected_results.push_back(make_result(nat_pkg::ST_NOT_FOUND,
						nat_pkg::CH_NONE, '0, '0, 1'b1));
				end
				results_due++;
			end
			default: begin
				if (shadow_count == 0) begin
					expected_results.push_back(make_result(nat_pkg::ST_OK, nat_pkg::CH_NONE,
						'0, '0, 1'b1));
					results_due++;
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						expected_results.push_back(make_result(nat_pkg::ST_OK,
							nat_pkg::CH_NONE, '0, shadow_addr[i], i == shadow_count - 1));
						results_due++;
					end
				end
			end
		endcase
	endtask

	task automatic add_cmd(nat_pkg::cmd_t cmd, logic [47:0] addr, logic [31:0] payload,
			bit wait_idle);
		table_cmd_t c;
		c.cmd = cmd;
		c.addr = addr;
		c.payload = payload;
		c.wait_idle = wait_idle;
		pending_cmds.push_back(c);
	endtask

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected 0x%0h got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// driver: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= nat_pkg::CMD_STORE;
		end else begin
			if (s_tvalid && s_tready)
				predict_table_results(offered_cmd);
			if (s_tvalid && !s_tready) begin
				// hold the offered item
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pending_cmds[0].wait_idle &&
					results_due != results_seen + (m_tvalid && m_tready)) begin
				s_tvalid <= 1'b0;
			end else begin
				offered_cmd = pending_cmds.pop_front();
				s_tdata <= S_TDATA_W'({offered_cmd.payload, offered_cmd.addr});
				s_tuser <= offered_cmd.cmd;
				s_tvalid <= 1'b1;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: ready pattern picked at random from four modes, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cycle <= 0;
			rx_mode <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 64 == 0)
				rx_mode <= $urandom_range(0, 3);
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
				m_tready <= 1'b0;
			else
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= rx_cycle[0];
				endcase
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			got.payload = m_tdata[31:0];
			got.addr    = m_tdata[79:32];
			got.count   = m_tdata[84:80];
			got.status  = m_tuser[1:0];
			got.change  = m_tuser[3:2];
			got.last    = m_tlast;
			if (expected_results.size() == 0) begin
				$error("result transfer with no expectation pending");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("change_kind", want.change, got.change);
				check_field("found_payload", want.payload, got.payload);
				check_field("listed_address", want.addr, got.addr);
				check_field("entry_count", want.count, got.count);
				check_field("last", want.last, got.last);
			end
		end
	end

	initial begin
		table_cmd_t c;
		int unsigned pick;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = {$urandom(), $urandom()};

		// directed part
		add_cmd(nat_pkg::CMD_LIST, '1, '1, 1'b0);
		add_cmd(nat_pkg::CMD_STORE, addr_pool[0], '0, 1'b0);
		add_cmd(nat_pkg::CMD_STORE, addr_pool[1], '1, 1'b0);
		add_cmd(nat_pkg::CMD_LOOKUP, addr_pool[0], '1, 1'b0);
		add_cmd(nat_pkg::CMD_LOOKUP, addr_pool[1], '0, 1'b0);
		add_cmd(nat_pkg::CMD_LOOKUP, addr_pool[2], '0, 1'b0);
		add_cmd(nat_pkg::CMD_FORGET, addr_pool[2], '0, 1'b0);
		add_cmd(nat_pkg::CMD_STORE, addr_pool[0], 32'h5a5a_a5a5, 1'b0);
		for (int i = 2; i < TABLE_DEPTH; i++)
			add_cmd(nat_pkg::CMD_STORE, addr_pool[i], $urandom(), 1'b0);
		// table full: new address refused, present one still updated
		add_cmd(nat_pkg::CMD_STORE, addr_pool[TABLE_DEPTH], $urandom(), 1'b0);
		add_cmd(nat_pkg::CMD_STORE, addr_pool[1], $urandom(), 1'b0);
		add_cmd(nat_pkg::CMD_LIST, '0, '0, 1'b1);
		add_cmd(nat_pkg::CMD_FORGET, addr_pool[TABLE_DEPTH-1], '0, 1'b0);
		add_cmd(nat_pkg::CMD_FORGET, addr_pool[0], '0, 1'b0);
		add_cmd(nat_pkg::CMD_LOOKUP, addr_pool[TABLE_DEPTH-2], '0, 1'b0);

		// random part: mostly pool addresses so that hits, fills and removals happen
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				c.cmd = nat_pkg::CMD_STORE;
			else if (pick < 65)
				c.cmd = nat_pkg::CMD_LOOKUP;
			else if (pick < 90)
				c.cmd = nat_pkg::CMD_FORGET;
			else
				c.cmd = nat_pkg::CMD_LIST;
			if ($urandom_range(0, 99) < 85)
				c.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				c.addr = {$urandom(), $urandom()};
			c.payload = $urandom();
			c.wait_idle = (n == 0) || ($urandom_range(0, 99) < 3);
			pending_cmds.push_back(c);
		end

		@(posedge arst_n);
		while (pending_cmds.size() != 0 || s_tvalid)
			@(posedge clk);
		while (results_seen != results_due)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("node_address_table test passed");
		else
			$display("node_address_table test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("node_address_table test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/nat_pkg.sv
sv/nat_datapath.sv
sv/nat_ctrl.sv
sv/node_address_table.sv
tb/node_address_table_tb.sv
